@@ rtl/vm_image_header_checker_top_assert.svh @@
// Assertion macros for the image header checker.
// Used by the checker module that is bound to the top level; no other dependencies.
`ifndef VM_IMAGE_HEADER_CHECKER_TOP_ASSERT_SVH
`define VM_IMAGE_HEADER_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VMIHC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vmihc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define VMIHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vmihc assertion failed");

`endif

@@ rtl/vmihc_pkg.sv @@
// Package for the image header checker: status codes, header constants and the hash step.
// Used by the channel interfaces, the top level and the checker; depends on nothing.
package vmihc_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_FLAGS    = 3'd4,
    ST_SIZE     = 3'd5,
    ST_ENTRY    = 3'd6,
    ST_CHECKSUM = 3'd7
  } status_t;

  localparam int unsigned CntW = 33;

  typedef logic [CntW-1:0] count_t;

  localparam count_t      HdrBytes    = 33'd16;
  localparam count_t      CountMax    = {CntW{1'b1}};
  localparam logic [31:0] FnvBasis    = 32'd2166136261;
  localparam logic [31:0] FnvPrime    = 32'd16777619;
  localparam logic [7:0]  DefVersion  = 8'd1;

  // Magic bytes expected at header offsets zero to three.
  localparam logic [7:0] Magic [4] = '{8'h43, 8'h4C, 8'h56, 8'h4D};

  // One FNV-1a round: fold the byte in, then multiply by the prime modulo 2^32.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

@@ rtl/vmihc_if.sv @@
// Channel interfaces for the image header checker: the byte request channel and the verdict channel.
// Depends on vmihc_pkg for the status type.
interface vmihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface vmihc_out_if;
  logic                  valid;
  logic                  ready;
  vmihc_pkg::status_t    status;
  logic [7:0]            version;
  logic [15:0]           entry_point;
  logic [31:0]           code_length;
  logic [31:0]           computed_hash;

  modport source (output valid, status, version, entry_point, code_length, computed_hash,
                  input ready);
  modport sink (input valid, status, version, entry_point, code_length, computed_hash,
                output ready);
endinterface

@@ rtl/vm_image_header_checker_top.sv @@
// Top level of the image header checker: header capture, FNV-1a hash and verdict.
// Depends on vmihc_pkg and the channel interfaces in vmihc_if.sv.
//
//   channel   | direction | carries
//   ----------+-----------+---------------------------------------------------
//   in_ch     | sink      | data_byte, last_byte (one file byte per request)
//   out_ch    | source    | status, version, entry_point, code_length, hash
//   cfg       | write     | cfg_wr_en, cfg_wr_data (expected version)
//
// One byte is taken every cycle unless in_ch stops; the verdict is registered.
// Each byte passes an input register, then one pass of update logic whose longest path is
// the 32-bit constant multiply of the hash followed by the checksum compare.
// Intermediate bytes never wait on the verdict channel; a final byte waits in the input
// register only while the previous verdict is still held, which stops in_ch for that time.
// Synchronous reset clears all file state and sets the expected version to one.
module vm_image_header_checker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  vmihc_in_if.sink            in_ch,
  vmihc_out_if.source         out_ch
);

  logic [7:0]          expected_version;

  // Input register.
  logic                in_vld;
  logic [7:0]          in_byte;
  logic                in_last;

  // File state.
  vmihc_pkg::count_t   byte_counter;
  logic                magic_good;
  logic [7:0]          header_version;
  logic [7:0]          header_flags;
  logic [15:0]         header_entry;
  logic [31:0]         header_length;
  logic [31:0]         header_checksum;
  logic [31:0]         running_hash;

  vmihc_pkg::count_t   byte_counter_next;
  logic                magic_good_next;
  logic [7:0]          header_version_next;
  logic [7:0]          header_flags_next;
  logic [15:0]         header_entry_next;
  logic [31:0]         header_length_next;
  logic [31:0]         header_checksum_next;
  logic [31:0]         running_hash_next;
  vmihc_pkg::status_t  verdict;

  // Output register.
  logic                out_vld;
  vmihc_pkg::status_t  out_status;
  logic [7:0]          out_version;
  logic [15:0]         out_entry;
  logic [31:0]         out_length;
  logic [31:0]         out_hash;

  logic                advance;
  logic                process;
  logic                load_out;
  logic                in_hdr;

  // A held byte can move on unless it is a final byte and the verdict slot is full.
  assign advance  = !in_last || !out_vld || out_ch.ready;
  assign process  = in_vld && advance;
  assign load_out = process && in_last;
  assign in_ch.ready = !in_vld || advance;

  assign in_hdr = (byte_counter[vmihc_pkg::CntW-1:4] == '0);

  always_comb begin
    byte_counter_next    = (byte_counter == vmihc_pkg::CountMax) ? byte_counter
                                                                 : byte_counter + 1'b1;
    magic_good_next      = magic_good;
    header_version_next  = header_version;
    header_flags_next    = header_flags;
    header_entry_next    = header_entry;
    header_length_next   = header_length;
    header_checksum_next = header_checksum;
    running_hash_next    = running_hash;
    if (in_hdr) begin
      case (byte_counter[3:0])
        4'd0, 4'd1, 4'd2, 4'd3: begin
          if (in_byte != vmihc_pkg::Magic[byte_counter[1:0]]) begin
            magic_good_next = 1'b0;
          end
        end
        4'd4:  header_version_next         = in_byte;
        4'd5:  header_flags_next           = in_byte;
        4'd6:  header_entry_next[7:0]      = in_byte;
        4'd7:  header_entry_next[15:8]     = in_byte;
        4'd8:  header_length_next[7:0]     = in_byte;
        4'd9:  header_length_next[15:8]    = in_byte;
        4'd10: header_length_next[23:16]   = in_byte;
        4'd11: header_length_next[31:24]   = in_byte;
        4'd12: header_checksum_next[7:0]   = in_byte;
        4'd13: header_checksum_next[15:8]  = in_byte;
        4'd14: header_checksum_next[23:16] = in_byte;
        default: header_checksum_next[31:24] = in_byte;
      endcase
    end else begin
      running_hash_next = vmihc_pkg::fnv_step(running_hash, in_byte);
    end
  end

  // Checks in order of priority, on the state as it stands after this byte.
  always_comb begin
    if (byte_counter_next < vmihc_pkg::HdrBytes) begin
      verdict = vmihc_pkg::ST_SHORT;
    end else if (!magic_good_next) begin
      verdict = vmihc_pkg::ST_MAGIC;
    end else if (header_version_next != expected_version) begin
      verdict = vmihc_pkg::ST_VERSION;
    end else if (header_flags_next != 8'd0) begin
      verdict = vmihc_pkg::ST_FLAGS;
    end else if (({1'b0, header_length_next} + vmihc_pkg::HdrBytes) != byte_counter_next) begin
      verdict = vmihc_pkg::ST_SIZE;
    end else if (({16'd0, header_entry_next} >= header_length_next) &&
                 (header_length_next != 32'd0)) begin
      verdict = vmihc_pkg::ST_ENTRY;
    end else if (running_hash_next != header_checksum_next) begin
      verdict = vmihc_pkg::ST_CHECKSUM;
    end else begin
      verdict = vmihc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= vmihc_pkg::DefVersion;
    end else if (cfg_wr_en) begin
      expected_version <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte <= in_ch.data_byte;
      in_last <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      byte_counter    <= '0;
      magic_good      <= 1'b1;
      header_version  <= 8'd0;
      header_flags    <= 8'd0;
      header_entry    <= 16'd0;
      header_length   <= 32'd0;
      header_checksum <= 32'd0;
      running_hash    <= vmihc_pkg::FnvBasis;
    end else if (process) begin
      byte_counter    <= byte_counter_next;
      magic_good      <= magic_good_next;
      header_version  <= header_version_next;
      header_flags    <= header_flags_next;
      header_entry    <= header_entry_next;
      header_length   <= header_length_next;
      header_checksum <= header_checksum_next;
      running_hash    <= running_hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load_out) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= verdict;
      if (verdict == vmihc_pkg::ST_SHORT) begin
        out_version <= 8'd0;
        out_entry   <= 16'd0;
        out_length  <= 32'd0;
        out_hash    <= vmihc_pkg::FnvBasis;
      end else begin
        out_version <= header_version_next;
        out_entry   <= header_entry_next;
        out_length  <= header_length_next;
        out_hash    <= running_hash_next;
      end
    end
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.status        = out_status;
  assign out_ch.version       = out_version;
  assign out_ch.entry_point   = out_entry;
  assign out_ch.code_length   = out_length;
  assign out_ch.computed_hash = out_hash;

endmodule

@@ rtl/vmihc_checker.sv @@
// Port-level checker for the image header checker, with the bind that attaches it.
// Depends on vmihc_pkg and the macros in vm_image_header_checker_top_assert.svh.
`include "vm_image_header_checker_top_assert.svh"

module vmihc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input vmihc_pkg::status_t status,
  input logic [7:0]         version,
  input logic [15:0]        entry_point,
  input logic [31:0]        code_length,
  input logic [31:0]        computed_hash
);

  // A short file reports no header fields and an untouched hash.
  `VMIHC_ASSERT_NOW(a_short_fields, clk, rst,
    out_valid && (status == vmihc_pkg::ST_SHORT),
    (version == 8'd0) && (entry_point == 16'd0) && (code_length == 32'd0) &&
    (computed_hash == vmihc_pkg::FnvBasis))

  // An entry failure needs a non-empty code section that the entry point lies beyond.
  `VMIHC_ASSERT_NOW(a_entry_fail, clk, rst,
    out_valid && (status == vmihc_pkg::ST_ENTRY),
    (code_length != 32'd0) && ({16'd0, entry_point} >= code_length))

  // A passing image has its entry point inside the code, or has no code at all.
  `VMIHC_ASSERT_NOW(a_ok_entry, clk, rst,
    out_valid && (status == vmihc_pkg::ST_OK),
    (code_length == 32'd0) || ({16'd0, entry_point} < code_length))

  // A verdict that is not taken stays as it is.
  `VMIHC_ASSERT_NEXT(a_out_hold, clk, rst,
    out_valid && !out_ready,
    out_valid && $stable(status) && $stable(computed_hash) && $stable(code_length))

endmodule

bind vm_image_header_checker_top vmihc_checker u_vmihc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .version       (out_ch.version),
  .entry_point   (out_ch.entry_point),
  .code_length   (out_ch.code_length),
  .computed_hash (out_ch.computed_hash)
);
